// ===== rtl/tsalu_pkg.sv =====
// shared types and constants for the timestamp arithmetic unit
`default_nettype none
package tsalu_pkg;

	localparam logic [3:0] OP_ADD  = 4'd0;
	localparam logic [3:0] OP_SUB  = 4'd1;
	localparam logic [3:0] OP_MUL  = 4'd2;
	localparam logic [3:0] OP_DIV  = 4'd3;
	localparam logic [3:0] OP_MOD  = 4'd4;
	localparam logic [3:0] OP_CMP  = 4'd5;
	localparam logic [3:0] OP_MSEC = 4'd6;
	localparam logic [3:0] OP_USEC = 4'd7;
	localparam logic [3:0] OP_TICK = 4'd8;

	localparam logic [31:0] NS_PER_SEC   = 32'd1000000000;
	localparam logic [31:0] MSEC_DIV     = 32'd1000;
	localparam logic [31:0] TICK_DIV     = 32'd10000000;
	localparam logic [31:0] NS_PER_MSEC  = 32'd1000000;
	localparam logic [31:0] NS_PER_TICK  = 32'd100;
	localparam logic [31:0] NS_PER_USEC  = 32'd1000;

	typedef struct packed {
		logic        vld;
		logic [3:0]  op;
		logic        err;
		logic [63:0] rs;
		logic [29:0] rn;
		logic        eq;
		logic        lt;
		logic        gt;
		logic [29:0] an;
		logic [63:0] aux;
	} pay_t;

endpackage
`default_nettype wire

// ===== rtl/tsalu_div_cell.sv =====
// one restoring division step with its request payload
`default_nettype none
module tsalu_div_cell #(
	parameter int DW = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [31:0]      in_rem,
	input  wire logic [DW-1:0]    in_dq,
	input  wire logic [31:0]      in_dvs,
	input  wire tsalu_pkg::pay_t  in_pl,
	output logic      [31:0]      out_rem,
	output logic      [DW-1:0]    out_dq,
	output logic      [31:0]      out_dvs,
	output tsalu_pkg::pay_t       out_pl
);
	import tsalu_pkg::*;

	logic [32:0] t;
	logic        ge;
	logic [32:0] diff;

	assign t    = {in_rem, in_dq[DW-1]};
	assign ge   = t >= {1'b0, in_dvs};
	assign diff = t - {1'b0, in_dvs};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_pl <= '0;
		end else begin
			out_pl <= in_pl;
		end
	end

	always_ff @(posedge clk) begin
		out_rem <= ge ? diff[31:0] : t[31:0];
		out_dq  <= {in_dq[DW-2:0], ge};
		out_dvs <= in_dvs;
	end

endmodule
`default_nettype wire

// ===== rtl/tsalu_div_chain.sv =====
// row of division cells, one quotient bit per cell
`default_nettype none
module tsalu_div_chain #(
	parameter int DW = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [31:0]      in_rem,
	input  wire logic [DW-1:0]    in_dq,
	input  wire logic [31:0]      in_dvs,
	input  wire tsalu_pkg::pay_t  in_pl,
	output logic      [31:0]      out_rem,
	output logic      [DW-1:0]    out_dq,
	output logic      [31:0]      out_dvs,
	output tsalu_pkg::pay_t       out_pl
);
	import tsalu_pkg::*;

	logic [31:0]   rem_w [0:DW];
	logic [DW-1:0] dq_w  [0:DW];
	logic [31:0]   dvs_w [0:DW];
	pay_t          pl_w  [0:DW];

	assign rem_w[0] = in_rem;
	assign dq_w[0]  = in_dq;
	assign dvs_w[0] = in_dvs;
	assign pl_w[0]  = in_pl;

	for (genvar i = 0; i < DW; i++) begin : g_cell
		tsalu_div_cell #(.DW(DW)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.in_rem(rem_w[i]), .in_dq(dq_w[i]), .in_dvs(dvs_w[i]), .in_pl(pl_w[i]),
			.out_rem(rem_w[i+1]), .out_dq(dq_w[i+1]), .out_dvs(dvs_w[i+1]),
			.out_pl(pl_w[i+1])
		);
	end

	assign out_rem = rem_w[DW];
	assign out_dq  = dq_w[DW];
	assign out_dvs = dvs_w[DW];
	assign out_pl  = pl_w[DW];

endmodule
`default_nettype wire

// ===== rtl/timestamp_sec_nsec_alu_core.sv =====
// top level of the timestamp arithmetic unit
//
// channel   direction  handshake          fields
// request   in         start, busy        operation a_sec a_nsec b_sec b_nsec ratio tick_count micro
// result    out        done               result_sec result_nsec is_equal is_less is_greater error
//
// one request per cycle; each passes the entry register, the 64-cell division row, the middle
// register, the 31-cell division row and the output register before done rises
// busy is always low; reset clears all valid flags in flight
// the receiver cannot stall, each result shows for one cycle with done high
`default_nettype none
module timestamp_sec_nsec_alu_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic        [3:0]  operation,
	input  wire logic signed [63:0] a_sec,
	input  wire logic        [29:0] a_nsec,
	input  wire logic signed [63:0] b_sec,
	input  wire logic        [29:0] b_nsec,
	input  wire logic        [31:0] ratio,
	input  wire logic        [62:0] tick_count,
	input  wire logic        [19:0] micro,
	output logic                    done,
	output logic signed [63:0]      result_sec,
	output logic        [29:0]      result_nsec,
	output logic                    is_equal,
	output logic                    is_less,
	output logic                    is_greater,
	output logic                    error
);
	import tsalu_pkg::*;

	localparam int DWA = 64;
	localparam int DWB = 31;

	assign busy = 1'b0;

	// entry stage
	pay_t        pay_n;
	logic [63:0] dvd_n;
	logic [31:0] dvs_n;
	logic [31:0] n0, d1, n7;
	logic [1:0]  k;
	logic [63:0] ka, kb;

	always_comb begin
		pay_n     = '0;
		pay_n.vld = start;
		pay_n.op  = operation;
		pay_n.an  = a_nsec;
		dvd_n     = 64'(tick_count);
		dvs_n     = TICK_DIV;
		n0 = 32'(a_nsec) + 32'(b_nsec);
		d1 = (a_nsec >= b_nsec) ? 32'(a_nsec) - 32'(b_nsec) : 32'(b_nsec) - 32'(a_nsec);
		n7 = 32'(micro) * NS_PER_USEC;
		k  = 2'd0;
		ka = a_sec ^ 64'h8000_0000_0000_0000;
		kb = b_sec ^ 64'h8000_0000_0000_0000;
		case (operation)
			OP_ADD: begin
				k = (n0 >= 2 * NS_PER_SEC) ? 2'd2 : (n0 >= NS_PER_SEC) ? 2'd1 : 2'd0;
				pay_n.rs = a_sec + b_sec + 64'(k);
				pay_n.rn = 30'(n0 - 32'(k) * NS_PER_SEC);
			end
			OP_SUB: begin
				if (a_nsec >= b_nsec) begin
					k = (d1 >= NS_PER_SEC) ? 2'd1 : 2'd0;
					pay_n.rs = a_sec - b_sec + 64'(k);
					pay_n.rn = 30'(d1 - 32'(k) * NS_PER_SEC);
				end else begin
					k = (d1 > NS_PER_SEC) ? 2'd2 : 2'd1;
					pay_n.rs = a_sec - b_sec - 64'(k);
					pay_n.rn = 30'(32'(k) * NS_PER_SEC - d1);
				end
			end
			OP_MUL, OP_DIV, OP_MOD: begin
				pay_n.err = (ratio == 32'd0) || a_sec[63];
				dvd_n = a_sec;
				dvs_n = (operation == OP_MUL) ? NS_PER_SEC : ratio;
			end
			OP_CMP: begin
				pay_n.lt = (ka < kb) || ((ka == kb) && (a_nsec < b_nsec));
				pay_n.gt = (ka > kb) || ((ka == kb) && (a_nsec > b_nsec));
				pay_n.eq = (ka == kb) && (a_nsec == b_nsec);
			end
			OP_MSEC: begin
				dvs_n = MSEC_DIV;
			end
			OP_USEC: begin
				k = (n7 >= NS_PER_SEC) ? 2'd1 : 2'd0;
				pay_n.rs = a_sec + 64'(k);
				pay_n.rn = 30'(n7 - 32'(k) * NS_PER_SEC);
			end
			default: begin
			end
		endcase
	end

	pay_t        pay_s1;
	logic [63:0] dvd_s1, pl_s1;
	logic [31:0] dvs_s1, ph_s1;
	logic [61:0] p_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pay_s1 <= '0;
		end else begin
			pay_s1 <= pay_n;
		end
	end

	always_ff @(posedge clk) begin
		dvd_s1 <= dvd_n;
		dvs_s1 <= dvs_n;
		pl_s1  <= 64'(a_sec[31:0]) * 64'(ratio);
		ph_s1  <= 32'(64'(a_sec[63:32]) * 64'(ratio));
		p_s1   <= 62'(64'(a_nsec) * 64'(ratio));
	end

	pay_t        ent_pl;
	logic [63:0] ent_dq;

	always_comb begin
		ent_pl     = pay_s1;
		ent_pl.aux = pl_s1 + {ph_s1, 32'd0};
		ent_dq     = (pay_s1.op == OP_MUL) ? 64'(p_s1) : dvd_s1;
	end

	logic [31:0]    ra, dvsa;
	logic [DWA-1:0] qa;
	pay_t           pa;

	tsalu_div_chain #(.DW(DWA)) u_chain_a (
		.clk(clk), .arst_n(arst_n),
		.in_rem(32'd0), .in_dq(ent_dq), .in_dvs(dvs_s1), .in_pl(ent_pl),
		.out_rem(ra), .out_dq(qa), .out_dvs(dvsa), .out_pl(pa)
	);

	// middle stage
	pay_t        mid_n;
	logic [63:0] part;

	always_comb begin
		mid_n = pa;
		part  = 64'(ra) * 64'(NS_PER_SEC) + 64'(pa.an);
		if (pa.vld && !pa.err) begin
			case (pa.op)
				OP_MUL: begin
					mid_n.rs = pa.aux + qa;
					mid_n.rn = ra[29:0];
				end
				OP_DIV: begin
					mid_n.aux = qa;
				end
				OP_MSEC: begin
					mid_n.rs = qa;
					mid_n.rn = 30'(ra * NS_PER_MSEC);
				end
				OP_TICK: begin
					mid_n.rs = qa;
					mid_n.rn = 30'(ra * NS_PER_TICK);
				end
				default: begin
				end
			endcase
		end
	end

	pay_t        pay_s2;
	logic [61:0] part_s2;
	logic [31:0] dvs_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pay_s2 <= '0;
		end else begin
			pay_s2 <= mid_n;
		end
	end

	always_ff @(posedge clk) begin
		part_s2 <= part[61:0];
		dvs_s2  <= dvsa;
	end

	logic [31:0]    rb, dvsb;
	logic [DWB-1:0] qb;
	pay_t           pb;

	tsalu_div_chain #(.DW(DWB)) u_chain_b (
		.clk(clk), .arst_n(arst_n),
		.in_rem({1'b0, part_s2[61:31]}), .in_dq(part_s2[30:0]), .in_dvs(dvs_s2),
		.in_pl(pay_s2),
		.out_rem(rb), .out_dq(qb), .out_dvs(dvsb), .out_pl(pb)
	);

	// output stage
	pay_t        fin;
	logic [31:0] qv;
	logic [2:0]  kq;
	logic [31:0] mq;

	always_comb begin
		fin = pb;
		qv  = 32'(qb);
		kq  = 3'd0;
		mq  = rb;
		if (pb.vld && !pb.err) begin
			case (pb.op)
				OP_DIV: begin
					kq = (qv >= 2 * NS_PER_SEC) ? 3'd2 : (qv >= NS_PER_SEC) ? 3'd1 : 3'd0;
					fin.rs = pb.aux + 64'(kq);
					fin.rn = 30'(qv - 32'(kq) * NS_PER_SEC);
				end
				OP_MOD: begin
					kq = (mq >= 4 * NS_PER_SEC) ? 3'd4 : (mq >= 3 * NS_PER_SEC) ? 3'd3 :
					     (mq >= 2 * NS_PER_SEC) ? 3'd2 : (mq >= NS_PER_SEC) ? 3'd1 : 3'd0;
					fin.rs = 64'(kq);
					fin.rn = 30'(mq - 32'(kq) * NS_PER_SEC);
				end
				default: begin
				end
			endcase
		end
		if (dvsb == 32'd0) begin
			fin.err = pb.err;
		end
	end

	logic done_q;
	logic [63:0] rs_q;
	logic [29:0] rn_q;
	logic eq_q, lt_q, gt_q, err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= fin.vld;
		end
	end

	always_ff @(posedge clk) begin
		rs_q  <= fin.rs;
		rn_q  <= fin.rn;
		eq_q  <= fin.eq;
		lt_q  <= fin.lt;
		gt_q  <= fin.gt;
		err_q <= fin.err;
	end

	assign done        = done_q;
	assign result_sec  = rs_q;
	assign result_nsec = rn_q;
	assign is_equal    = eq_q;
	assign is_less     = lt_q;
	assign is_greater  = gt_q;
	assign error       = err_q;

endmodule
`default_nettype wire

// ===== bench/timestamp_sec_nsec_alu_core_tb.sv =====
// self-checking testbench for the timestamp arithmetic unit
`default_nettype none
module timestamp_sec_nsec_alu_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tsalu_pkg::*;

	typedef struct packed {
		logic [3:0]  op;
		logic [63:0] as;
		logic [29:0] an;
		logic [63:0] bs;
		logic [29:0] bn;
		logic [31:0] ratio;
		logic [62:0] ticks;
		logic [19:0] micro;
	} req_t;

	typedef struct packed {
		logic [63:0] rs;
		logic [29:0] rn;
		logic        eq;
		logic        lt;
		logic        gt;
		logic        err;
	} ts_res_t;

	localparam int LIMIT = 200000;
	localparam logic [63:0] NS = 64'd1000000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [3:0] operation = '0;
	logic signed [63:0] a_sec = '0;
	logic [29:0] a_nsec = '0;
	logic signed [63:0] b_sec = '0;
	logic [29:0] b_nsec = '0;
	logic [31:0] ratio = '0;
	logic [62:0] tick_count = '0;
	logic [19:0] micro = '0;
	logic busy, done, is_equal, is_less, is_greater, error;
	logic signed [63:0] result_sec;
	logic [29:0] result_nsec;

	timestamp_sec_nsec_alu_core u_dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	ts_res_t pending_q[$];
	int fails = 0;
	int cycles = 0;
	int n_req = 0;
	int n_res = 0;

	function automatic ts_res_t ts_compute(req_t r);
		ts_res_t o;
		logic [63:0] n, d, k, p, part, q, m, ka, kb, rt;
		o = '0;
		rt = {32'd0, r.ratio};
		case (r.op)
			OP_ADD: begin
				n = r.an + r.bn;
				o.rs = r.as + r.bs + n / NS;
				o.rn = 30'(n % NS);
			end
			OP_SUB: begin
				if (r.an >= r.bn) begin
					d = r.an - r.bn;
					o.rs = r.as - r.bs + d / NS;
					o.rn = 30'(d % NS);
				end else begin
					d = r.bn - r.an;
					k = 1 + (d - 1) / NS;
					o.rs = r.as - r.bs - k;
					o.rn = 30'(k * NS - d);
				end
			end
			OP_MUL, OP_DIV, OP_MOD: begin
				if (r.ratio == 0 || r.as[63]) begin
					o.err = 1'b1;
				end else if (r.op == OP_MUL) begin
					p = r.an * rt;
					o.rs = r.as * rt + p / NS;
					o.rn = 30'(p % NS);
				end else begin
					part = NS * (r.as % rt) + r.an;
					if (r.op == OP_DIV) begin
						q = part / rt;
						o.rs = r.as / rt + q / NS;
						o.rn = 30'(q % NS);
					end else begin
						m = part % rt;
						o.rs = m / NS;
						o.rn = 30'(m % NS);
					end
				end
			end
			OP_CMP: begin
				ka = r.as ^ 64'h8000000000000000;
				kb = r.bs ^ 64'h8000000000000000;
				if (ka < kb || (ka == kb && r.an < r.bn)) o.lt = 1'b1;
				else if (ka > kb || (ka == kb && r.an > r.bn)) o.gt = 1'b1;
				else o.eq = 1'b1;
			end
			OP_MSEC: begin
				o.rs = r.ticks / 1000;
				o.rn = 30'((r.ticks % 1000) * 1000000);
			end
			OP_USEC: begin
				n = r.micro * 64'd1000;
				o.rs = r.as + n / NS;
				o.rn = 30'(n % NS);
			end
			OP_TICK: begin
				o.rs = r.ticks / 10000000;
				o.rn = 30'((r.ticks % 10000000) * 100);
			end
			default: ;
		endcase
		return o;
	endfunction

	function automatic req_t rand_req(bit noise);
		req_t r;
		r.op = noise ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
		r.as = {$urandom, $urandom};
		r.bs = {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: r.as = 64'($signed(32'($urandom_range(0, 2000))) - 1000);
			1: r.bs = r.as;
			default: ;
		endcase
		r.an = ($urandom_range(0, 9) == 0) ? 30'($urandom) : 30'($urandom_range(0, 999999999));
		r.bn = ($urandom_range(0, 9) == 0) ? 30'($urandom) : 30'($urandom_range(0, 999999999));
		if ($urandom_range(0, 7) == 0) r.bn = r.an;
		case ($urandom_range(0, 3))
			0: r.ratio = $urandom_range(0, 10);
			1: r.ratio = $urandom_range(0, 1000000);
			default: r.ratio = $urandom;
		endcase
		r.ticks = 63'({$urandom, $urandom});
		r.micro = ($urandom_range(0, 9) == 0) ? 20'($urandom) : 20'($urandom_range(0, 999999));
		return r;
	endfunction

	// directed rows, expected value typed in where obvious
	typedef struct packed {
		req_t    rq;
		logic    known;
		ts_res_t ex;
	} row_t;

	row_t rows[$];

	function automatic row_t mk(logic [3:0] op, logic [63:0] as, logic [29:0] an,
			logic [63:0] bs, logic [29:0] bn, logic [31:0] rt, logic [62:0] tk,
			logic [19:0] mi, logic known, ts_res_t ex);
		row_t w;
		w.rq = '{op, as, an, bs, bn, rt, tk, mi};
		w.known = known;
		w.ex = ex;
		return w;
	endfunction

	initial begin
		localparam logic [63:0] MAXS = 64'h7FFFFFFFFFFFFFFF;
		localparam logic [63:0] MINS = 64'h8000000000000000;
		rows.push_back(mk(OP_ADD, 0, 0, 0, 0, 0, 0, 0, 1, '0));
		rows.push_back(mk(OP_ADD, MAXS, 999999999, 1, 1, 0, 0, 0, 0, '0));
		rows.push_back(mk(OP_ADD, 5, 30'h3FFFFFFF, 0, 30'h3FFFFFFF, 0, 0, 0, 0, '0));
		rows.push_back(mk(OP_SUB, MINS, 0, 1, 999999999, 0, 0, 0, 0, '0));
		rows.push_back(mk(OP_SUB, 3, 30'h3FFFFFFF, 1, 0, 0, 0, 0, 0, '0));
		rows.push_back(mk(OP_SUB, 0, 0, 0, 30'h3FFFFFFF, 0, 0, 0, 0, '0));
		rows.push_back(mk(OP_MUL, 5, 7, 0, 0, 0, 0, 0, 1, '{0, 0, 0, 0, 0, 1}));
		rows.push_back(mk(OP_DIV, -64'sd1, 7, 0, 0, 3, 0, 0, 1, '{0, 0, 0, 0, 0, 1}));
		rows.push_back(mk(OP_MOD, MINS, 7, 0, 0, 3, 0, 0, 1, '{0, 0, 0, 0, 0, 1}));
		rows.push_back(mk(OP_MUL, MAXS, 999999999, 0, 0, 32'hFFFFFFFF, 0, 0, 0, '0));
		rows.push_back(mk(OP_DIV, MAXS, 30'h3FFFFFFF, 0, 0, 32'hFFFFFFFF, 0, 0, 0, '0));
		rows.push_back(mk(OP_DIV, MAXS, 999999999, 0, 0, 1, 0, 0, 0, '0));
		rows.push_back(mk(OP_MOD, MAXS, 999999999, 0, 0, 32'hFFFFFFFF, 0, 0, 0, '0));
		rows.push_back(mk(OP_MOD, 12345, 30'h3FFFFFFF, 0, 0, 7, 0, 0, 0, '0));
		rows.push_back(mk(OP_CMP, MINS, 0, MAXS, 0, 0, 0, 0, 1, '{0, 0, 0, 1, 0, 0}));
		rows.push_back(mk(OP_CMP, MAXS, 0, MINS, 0, 0, 0, 0, 1, '{0, 0, 0, 0, 1, 0}));
		rows.push_back(mk(OP_CMP, 9, 5, 9, 5, 0, 0, 0, 1, '{0, 0, 1, 0, 0, 0}));
		rows.push_back(mk(OP_CMP, 9, 30'h3FFFFFFF, 9, 5, 0, 0, 0, 1, '{0, 0, 0, 0, 1, 0}));
		rows.push_back(mk(OP_MSEC, 0, 0, 0, 0, 0, 63'h7FFFFFFFFFFFFFFF, 0, 0, '0));
		rows.push_back(mk(OP_MSEC, 0, 0, 0, 0, 0, 999, 0, 1, '{0, 999000000, 0, 0, 0, 0}));
		rows.push_back(mk(OP_USEC, MAXS, 0, 0, 0, 0, 0, 20'hFFFFF, 0, '0));
		rows.push_back(mk(OP_USEC, -64'sd1, 0, 0, 0, 0, 0, 999999, 0, '0));
		rows.push_back(mk(OP_TICK, 0, 0, 0, 0, 0, 63'h7FFFFFFFFFFFFFFF, 0, 0, '0));
		rows.push_back(mk(4'd9, MAXS, 5, MAXS, 5, 5, 5, 5, 1, '0));
		rows.push_back(mk(4'd15, -64'sd1, 30'h3FFFFFFF, -64'sd1, 30'h3FFFFFFF,
			32'hFFFFFFFF, 63'h7FFFFFFFFFFFFFFF, 20'hFFFFF, 1, '0));
	end

	task automatic issue(req_t r, ts_res_t ex);
		start <= 1'b1;
		{operation, a_sec, a_nsec, b_sec, b_nsec, ratio, tick_count, micro} <= r;
		pending_q.push_back(ex);
		n_req++;
		do @(posedge clk); while (busy);
	endtask

	task automatic idle_burst(bit allow);
		if (allow && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	// result side
	always @(posedge clk) begin
		ts_res_t e;
		if (arst_n && done) begin
			n_res++;
			if (pending_q.size() == 0) begin
				$error("unexpected result");
				fails++;
			end else begin
				e = pending_q.pop_front();
				if (result_sec !== e.rs) begin
					$error("result_sec exp %0h got %0h", e.rs, result_sec); fails++;
				end
				if (result_nsec !== e.rn) begin
					$error("result_nsec exp %0d got %0d", e.rn, result_nsec); fails++;
				end
				if (is_equal !== e.eq) begin
					$error("is_equal exp %0b got %0b", e.eq, is_equal); fails++;
				end
				if (is_less !== e.lt) begin
					$error("is_less exp %0b got %0b", e.lt, is_less); fails++;
				end
				if (is_greater !== e.gt) begin
					$error("is_greater exp %0b got %0b", e.gt, is_greater); fails++;
				end
				if (error !== e.err) begin
					$error("error exp %0b got %0b", e.err, error); fails++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		req_t r;
		ts_res_t ex;
		int k;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i]) begin
			ex = rows[i].known ? rows[i].ex : ts_compute(rows[i].rq);
			issue(rows[i].rq, ex);
			idle_burst(1);
		end
		for (k = 0; k < 950; k++) begin
			r = rand_req($urandom_range(0, 19) == 0);
			issue(r, ts_compute(r));
			idle_burst(k < 800);
		end
		start <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
		$display("covered %0d requests over all operations, %0d results checked", n_req, n_res);
		if (fails == 0 && pending_q.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
`default_nettype wire
